// ----- src/bba_pkg.sv -----
// shared types and constants of the bitmap block allocator
package bba_pkg;

  // default geometry
  localparam int NUM_BLOCKS_DEF     = 512;
  localparam int RESERVED_START_DEF = 0;
  localparam int RESERVED_COUNT_DEF = 1;

  // bitmap word layout
  localparam int WORD_W     = 32;
  localparam int BIT_W      = 5;
  localparam int GROUP_W    = 8;
  localparam int GROUP_BITS = 3;

  // field widths
  localparam int ID_W    = 12;
  localparam int COUNT_W = 13;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_REQUEST = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GRP,
    S_WRD,
    S_RD,
    S_MOD,
    S_RESP
  } state_t;

endpackage

// ----- src/bba_ram.sv -----
// generic single-port-write, registered-read ram
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/bitmap_block_allocator_unit.sv -----
// bitmap block allocator top level: fsm, summary bits and bitmap memory
//
// One used bit per block, kept in 32-bit words in a synchronous ram, plus a
// flip-flop "word full" summary per word. After reset, block ids in the
// reserved run are used and blocks_used holds their number (ids past the end
// are skipped). An item is taken when start is high and busy is low; its
// result shows on the result ports for exactly one cycle with done high, one
// result per item, and the receiver cannot stall it. Steps from accept to
// done: allocate picks a non-full group of 8 words from the summary, picks
// the word in it, reads the ram, then modifies and writes back; request and
// release read, then modify/write; request or release with an out-of-range
// id and the unused action code go straight to the response; allocate with
// every block used does the summary check, then the response. busy stays
// high while an item is in progress, so no new item is taken before the
// last one's result. The ram read and the two-step summary search set these
// steps. No clearing pass is needed: a word never written since reset reads
// as its reset pattern.
module bitmap_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS     = NUM_BLOCKS_DEF,
  parameter int RESERVED_START = RESERVED_START_DEF,
  parameter int RESERVED_COUNT = RESERVED_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [ID_W-1:0]    req_block,
  output logic               done,
  output logic               ok,
  output logic [ID_W-1:0]    granted_block,
  output logic [COUNT_W-1:0] blocks_used,
  output logic [COUNT_W-1:0] blocks_free
);

  // geometry
  localparam int NWORDS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int NG_RAW  = (NWORDS + GROUP_W - 1) / GROUP_W;
  localparam int GW      = (NG_RAW > 1) ? $clog2(NG_RAW) : 1;
  localparam int NG      = 1 << GW;
  localparam int RES_END = (RESERVED_START + RESERVED_COUNT < NUM_BLOCKS) ?
                           (RESERVED_START + RESERVED_COUNT) : NUM_BLOCKS;
  localparam int RES_USED = (RESERVED_START >= NUM_BLOCKS) ? 0 :
                            (RES_END - RESERVED_START);
  localparam logic [COUNT_W-1:0] NB_C       = COUNT_W'(NUM_BLOCKS);
  localparam logic [COUNT_W-1:0] RES_USED_C = COUNT_W'(RES_USED);

  // bits past the last block, always seen as used
  function automatic logic [WORD_W-1:0] pad_word(input int w);
    logic [WORD_W-1:0] m;
    for (int b = 0; b < WORD_W; b++) begin
      m[b] = (w * WORD_W + b) >= NUM_BLOCKS;
    end
    return m;
  endfunction

  // reset contents of a word: the reserved run
  function automatic logic [WORD_W-1:0] rst_word(input int w);
    logic [WORD_W-1:0] m;
    int                id;
    for (int b = 0; b < WORD_W; b++) begin
      id   = w * WORD_W + b;
      m[b] = (id >= RESERVED_START) && (id < RESERVED_START + RESERVED_COUNT) &&
             (id < NUM_BLOCKS);
    end
    return m;
  endfunction

  state_t state, state_next;

  logic [1:0]         act_q;
  logic [ID_W-1:0]    id_q;
  logic [AW-1:0]      waddr;
  logic [GW-1:0]      grp_q;
  logic [COUNT_W-1:0] used_total;
  logic [NWORDS-1:0]  full;
  logic [NWORDS-1:0]  wvalid;
  logic               rd_valid_q;

  // ram interface
  logic              ram_we;
  logic              ram_re;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // summary search
  logic [GROUP_W-1:0] fp [NG];
  logic [NG-1:0]      gfull;
  logic               any_free;
  logic [GW-1:0]      grp_pick;
  logic [GROUP_BITS-1:0] wrd_pick;

  // read-modify-write
  logic [WORD_W-1:0]  weff;
  logic [WORD_W-1:0]  wsrch;
  logic [BIT_W-1:0]   fbit;
  logic [BIT_W-1:0]   sel_bit;
  logic [WORD_W-1:0]  wnew;

  // result
  logic               res_load;
  logic               res_ok;
  logic [ID_W-1:0]    res_grant;
  logic [COUNT_W-1:0] used_next;

  logic accept;
  logic in_range;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign in_range = {1'b0, req_block} < NB_C;

  // summary folded into groups of eight words, missing words read as full
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      for (int k = 0; k < GROUP_W; k++) begin
        if (g * GROUP_W + k < NWORDS) begin
          fp[g][k] = full[g * GROUP_W + k];
        end else begin
          fp[g][k] = 1'b1;
        end
      end
      gfull[g] = &fp[g];
    end
  end

  // lowest group with a free block
  always_comb begin
    any_free = 1'b0;
    grp_pick = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (!gfull[g]) begin
        any_free = 1'b1;
        grp_pick = GW'(g);
      end
    end
  end

  // lowest non-full word inside the chosen group
  always_comb begin
    wrd_pick = '0;
    for (int k = GROUP_W - 1; k >= 0; k--) begin
      if (!fp[grp_q][k]) begin
        wrd_pick = GROUP_BITS'(k);
      end
    end
  end

  // word as it stands: ram data once written, else reset pattern
  assign weff  = rd_valid_q ? ram_rdata : rst_word(int'(waddr));
  assign wsrch = weff | pad_word(int'(waddr));

  always_comb begin
    fbit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!wsrch[b]) begin
        fbit = BIT_W'(b);
      end
    end
  end

  assign sel_bit = (act_q == ACT_ALLOC) ? fbit : id_q[BIT_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_ALLOC) begin
            state_next = S_GRP;
          end else if ((action == ACT_REQUEST || action == ACT_RELEASE) && in_range) begin
            state_next = S_RD;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_GRP:   state_next = any_free ? S_WRD : S_RESP;
      S_WRD:   state_next = S_RD;
      S_RD:    state_next = S_MOD;
      S_MOD:   state_next = S_IDLE;
      S_RESP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the fsm: ram control and result
  always_comb begin
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = weff;
    res_load  = 1'b0;
    res_ok    = 1'b0;
    res_grant = '0;
    used_next = used_total;
    wnew      = weff;
    unique case (state)
      S_RD: begin
        ram_re = 1'b1;
      end
      S_MOD: begin
        res_load = 1'b1;
        case (act_q)
          ACT_ALLOC: begin
            wnew[sel_bit] = 1'b1;
            res_ok        = 1'b1;
            res_grant     = (ID_W'(waddr) << BIT_W) | ID_W'(fbit);
            used_next     = used_total + 1'b1;
          end
          ACT_REQUEST: begin
            if (!weff[sel_bit]) begin
              wnew[sel_bit] = 1'b1;
              res_ok        = 1'b1;
              res_grant     = id_q;
              used_next     = used_total + 1'b1;
            end
          end
          ACT_RELEASE: begin
            res_ok = 1'b1;
            if (weff[sel_bit]) begin
              wnew[sel_bit] = 1'b0;
              used_next     = used_total - 1'b1;
            end
          end
          default: begin
            res_ok = 1'b0;
          end
        endcase
        ram_we    = 1'b1;
        ram_wdata = wnew;
      end
      S_RESP: begin
        // failures and out-of-range release; release still reports ok
        res_load = 1'b1;
        res_ok   = (act_q == ACT_RELEASE);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // control and bookkeeping registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      used_total  <= RES_USED_C;
      wvalid      <= '0;
      done        <= 1'b0;
      blocks_used <= RES_USED_C;
      blocks_free <= NB_C - RES_USED_C;
      for (int w = 0; w < NWORDS; w++) begin
        full[w] <= &(rst_word(w) | pad_word(w));
      end
    end else begin
      state <= state_next;
      done  <= res_load;
      if (res_load) begin
        used_total  <= used_next;
        blocks_used <= used_next;
        blocks_free <= NB_C - used_next;
      end
      if (ram_we) begin
        wvalid[waddr] <= 1'b1;
        full[waddr]   <= &(wnew | pad_word(int'(waddr)));
      end
    end
  end

  // item and address registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q <= action;
      id_q  <= req_block;
      waddr <= req_block[BIT_W +: AW];
    end
    if (state == S_GRP) begin
      grp_q <= grp_pick;
    end
    if (state == S_WRD) begin
      waddr <= AW'({grp_q, wrd_pick});
    end
    if (ram_re) begin
      rd_valid_q <= wvalid[waddr];
    end
    if (res_load) begin
      ok            <= res_ok;
      granted_block <= res_grant;
    end
  end

  bba_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NWORDS),
    .AW   (AW)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(waddr),
    .rdata(ram_rdata)
  );

  // done only follows a modify or response cycle
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_MOD || $past(state) == S_RESP))
    else $error("done without a finishing state");

  // counts always add up to the number of blocks
  a_counts: assert property (@(posedge clk) disable iff (rst)
    (14'(blocks_used) + 14'(blocks_free)) == 14'(NUM_BLOCKS))
    else $error("used and free counts disagree");

  // an accepted item holds the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // a granted block lies inside the block range
  a_grant: assert property (@(posedge clk) disable iff (rst)
    (done && ok) |-> ({1'b0, granted_block} < NB_C))
    else $error("granted block out of range");

endmodule

// ----- dv/tb_bitmap_block_allocator_unit.sv -----
// testbench for the bitmap block allocator: directed and random items checked against a predictor
`timescale 1ns / 1ps

module tb_bitmap_block_allocator_unit;
  import bba_pkg::*;

  localparam int NB          = NUM_BLOCKS_DEF;
  localparam int RSV_START   = RESERVED_START_DEF;
  localparam int RSV_COUNT   = RESERVED_COUNT_DEF;
  localparam int MAX_ID      = (1 << ID_W) - 1;
  localparam int RANDOM_ITEMS = 700;
  localparam int MAX_REPORTS = 10;

  // action code that the package leaves unnamed
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic               ok;
    logic [ID_W-1:0]    granted;
    logic [COUNT_W-1:0] used;
    logic [COUNT_W-1:0] free;
  } alloc_outcome_t;

  class allocator_scoreboard;
    bit             block_used [NB];
    int unsigned    used_total;
    alloc_outcome_t pending_outcomes [$];
    int             fail_count;
    int             checked;
    int             n_alloc, n_alloc_refused, n_request, n_request_refused;
    int             n_release, n_unused;

    function new();
      for (int i = 0; i < NB; i++) block_used[i] = 1'b0;
      used_total = 0;
      // reserved run is taken at reset; ids past the end are skipped
      for (int k = 0; k < RSV_COUNT; k++) begin
        if (RSV_START + k < NB) begin
          block_used[RSV_START + k] = 1'b1;
          used_total++;
        end
      end
    endfunction

    function alloc_outcome_t predict_outcome(logic [1:0] act, logic [ID_W-1:0] id);
      alloc_outcome_t o;
      o.ok      = 1'b0;
      o.granted = '0;
      case (act)
        ACT_ALLOC: begin
          n_alloc++;
          for (int i = 0; i < NB; i++) begin
            if (!block_used[i]) begin
              block_used[i] = 1'b1;
              used_total++;
              o.ok      = 1'b1;
              o.granted = ID_W'(i);
              break;
            end
          end
          if (!o.ok) n_alloc_refused++;
        end
        ACT_REQUEST: begin
          n_request++;
          if (id < NB && !block_used[id]) begin
            block_used[id] = 1'b1;
            used_total++;
            o.ok      = 1'b1;
            o.granted = id;
          end else begin
            n_request_refused++;
          end
        end
        ACT_RELEASE: begin
          n_release++;
          o.ok = 1'b1;
          if (id < NB && block_used[id]) begin
            block_used[id] = 1'b0;
            used_total--;
          end
        end
        default: n_unused++;
      endcase
      o.used = COUNT_W'(used_total);
      o.free = COUNT_W'(NB - used_total);
      return o;
    endfunction

    function void note_item(logic [1:0] act, logic [ID_W-1:0] id);
      pending_outcomes.push_back(predict_outcome(act, id));
    endfunction

    function void check_outcome(logic ok, logic [ID_W-1:0] granted,
                                logic [COUNT_W-1:0] used, logic [COUNT_W-1:0] free);
      alloc_outcome_t e;
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("[%0t] result with nothing expected: ok=%0b granted=%0d",
                   $time, ok, granted, " used=%0d free=%0d", used, free);
        return;
      end
      e = pending_outcomes.pop_front();
      checked++;
      if (ok !== e.ok || granted !== e.granted || used !== e.used || free !== e.free) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("[%0t] mismatch: exp ok=%0b granted=%0d used=%0d free=%0d,",
                   $time, e.ok, e.granted, e.used, e.free,
                   " got ok=%0b granted=%0d used=%0d free=%0d",
                   ok, granted, used, free);
      end
    endfunction

    function int pick_used_block();
      int s;
      s = $urandom_range(0, NB - 1);
      for (int i = 0; i < NB; i++)
        if (block_used[(s + i) % NB]) return (s + i) % NB;
      return s;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         action = '0;
  logic [ID_W-1:0]    req_block = '0;
  logic               busy;
  logic               done;
  logic               ok;
  logic [ID_W-1:0]    granted_block;
  logic [COUNT_W-1:0] blocks_used;
  logic [COUNT_W-1:0] blocks_free;

  allocator_scoreboard sb = new();
  int burst_left = 0;

  always #6 clk = ~clk;

  bitmap_block_allocator_unit #(
    .NUM_BLOCKS     (NB),
    .RESERVED_START (RSV_START),
    .RESERVED_COUNT (RSV_COUNT)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .req_block     (req_block),
    .done          (done),
    .ok            (ok),
    .granted_block (granted_block),
    .blocks_used   (blocks_used),
    .blocks_free   (blocks_free)
  );

  // results are sampled at the edge that ends their cycle
  always @(posedge clk) begin
    if (!rst && done) sb.check_outcome(ok, granted_block, blocks_used, blocks_free);
  end

  // hold the item until an edge sees start high and busy low
  task automatic send_item(input logic [1:0] act, input logic [ID_W-1:0] id);
    start     <= 1'b1;
    action    <= act;
    req_block <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(act, id);
  endtask

  // bursts of back-to-back items separated by random gaps
  task automatic sender_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_outcomes.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic send_random(input int w_alloc, input int w_req, input int w_rel_used,
                             input int w_rel_any);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_alloc)
      send_item(ACT_ALLOC, ID_W'($urandom_range(0, MAX_ID)));
    else if (r < w_alloc + w_req)
      send_item(ACT_REQUEST, ID_W'($urandom_range(0, NB - 1)));
    else if (r < w_alloc + w_req + w_rel_used)
      send_item(ACT_RELEASE, ID_W'(sb.pick_used_block()));
    else if (r < w_alloc + w_req + w_rel_used + w_rel_any)
      send_item(ACT_RELEASE, ID_W'($urandom_range(0, NB - 1)));
    else
      // noise: any code, any id, out of range included
      send_item(2'($urandom_range(0, 3)), ID_W'($urandom_range(0, MAX_ID)));
    sender_gap();
  endtask

  initial begin
    int n_random;
    int extra;
    n_random = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every action and the refusal cases
    send_item(ACT_ALLOC, '0);
    send_item(ACT_ALLOC, ID_W'(MAX_ID));
    send_item(ACT_REQUEST, ID_W'(RSV_START));
    send_item(ACT_REQUEST, ID_W'(NB - 1));
    send_item(ACT_REQUEST, ID_W'(NB - 1));
    send_item(ACT_REQUEST, ID_W'(NB));
    send_item(ACT_REQUEST, ID_W'(MAX_ID));
    send_item(ACT_REQUEST, ID_W'('hAAA));
    send_item(ACT_REQUEST, ID_W'('h555));
    send_item(ACT_RELEASE, ID_W'(MAX_ID));
    send_item(ACT_RELEASE, ID_W'(NB));
    send_item(ACT_RELEASE, ID_W'(RSV_START));
    send_item(ACT_RELEASE, ID_W'(RSV_START));
    send_item(ACT_ALLOC, '0);
    send_item(ACT_UNUSED, '0);
    send_item(ACT_UNUSED, ID_W'(MAX_ID));
    send_item(ACT_RELEASE, ID_W'(NB - 1));
    send_item(ACT_RELEASE, ID_W'(1));
    send_item(ACT_ALLOC, ID_W'('h555));
    send_item(ACT_REQUEST, ID_W'(NB / 2));
    send_item(ACT_RELEASE, ID_W'(NB / 2));
    send_item(ACT_RELEASE, ID_W'(NB / 2));
    wait_drained();

    // fill the map, then keep hitting it while full
    while (sb.used_total < NB) begin
      send_random(85, 8, 2, 1);
      n_random++;
    end
    for (extra = 0; extra < 20; extra++) begin
      send_random(60, 25, 0, 0);
      n_random++;
    end
    wait_drained();

    // churn: frees and takes mixed, with noise
    while (n_random < RANDOM_ITEMS || extra < 120) begin
      send_random(30, 15, 28, 12);
      n_random++;
      extra++;
    end
    wait_drained();
    repeat (10) @(posedge clk);

    if (sb.pending_outcomes.size() != 0) sb.fail_count++;
    $display("ran %0d items: %0d allocates (%0d refused), %0d requests (%0d refused),",
             sb.checked, sb.n_alloc, sb.n_alloc_refused, sb.n_request, sb.n_request_refused);
    $display("  %0d releases and %0d unused codes; map filled to %0d blocks and churned",
             sb.n_release, sb.n_unused, NB);
    if (sb.fail_count == 0)
      $display("bitmap_block_allocator_unit test passed");
    else
      $display("bitmap_block_allocator_unit test failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("bitmap_block_allocator_unit test failed");
    $finish;
  end

endmodule
